FILE: sv/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg: shared types and defaults for the circle tangent point block
// Status codes, pipeline control bundle and default widths.
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int TOL_W           = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // Default widths of the inner units at the default coordinate width
  localparam int SQRT_RAD_W_DEF  = 126;
  localparam int SQRT_ROOT_W_DEF = SQRT_RAD_W_DEF / 2;
  localparam int DIV_Q_W_DEF     = 30;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_COINCIDENT = 2'd1,
    ST_INSIDE     = 2'd2,
    ST_BAD_RADIUS = 2'd3
  } status_t;

  // Pipeline control between stage groups
  typedef struct packed {
    logic en;     // advance all stages
    logic valid;  // entering transaction is valid
  } pipe_ctl_t;

endpackage

FILE: sv/ctp_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// ctp_sqrt_pipe: two-lane pipelined integer square root
// One result bit per stage, restoring method, a tag travels with each lane pair.
// ----------------------------------------------------------------------------
module ctp_sqrt_pipe import ctp_pkg::*; #(
  parameter int RAD_W = SQRT_RAD_W_DEF,
  parameter int TAG_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pipe_ctl_t             ctl,
  input  logic [RAD_W-1:0]      rad_a,
  input  logic [RAD_W-1:0]      rad_b,
  input  logic [TAG_W-1:0]      tag_in,
  output logic                  out_valid,
  output logic [RAD_W/2-1:0]    root_a,
  output logic [RAD_W/2-1:0]    root_b,
  output logic [TAG_W-1:0]      tag_out
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic              vld_r    [ROOT_W];
  logic [RAD_W-1:0]  rad_a_r  [ROOT_W];
  logic [RAD_W-1:0]  rad_b_r  [ROOT_W];
  logic [REM_W-1:0]  rem_a_r  [ROOT_W];
  logic [REM_W-1:0]  rem_b_r  [ROOT_W];
  logic [ROOT_W-1:0] root_a_r [ROOT_W];
  logic [ROOT_W-1:0] root_b_r [ROOT_W];
  logic [TAG_W-1:0]  tag_r    [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic              vld_p;
    logic [RAD_W-1:0]  rad_a_p, rad_b_p;
    logic [REM_W-1:0]  rem_a_p, rem_b_p;
    logic [ROOT_W-1:0] root_a_p, root_b_p;
    logic [TAG_W-1:0]  tag_p;
    logic [REM_W-1:0]  sh_a, sh_b, tr_a, tr_b;
    logic              ge_a, ge_b;

    if (i == 0) begin : g_first
      assign vld_p    = ctl.valid;
      assign rad_a_p  = rad_a;
      assign rad_b_p  = rad_b;
      assign rem_a_p  = '0;
      assign rem_b_p  = '0;
      assign root_a_p = '0;
      assign root_b_p = '0;
      assign tag_p    = tag_in;
    end else begin : g_next
      assign vld_p    = vld_r[i-1];
      assign rad_a_p  = rad_a_r[i-1];
      assign rad_b_p  = rad_b_r[i-1];
      assign rem_a_p  = rem_a_r[i-1];
      assign rem_b_p  = rem_b_r[i-1];
      assign root_a_p = root_a_r[i-1];
      assign root_b_p = root_b_r[i-1];
      assign tag_p    = tag_r[i-1];
    end

    // bring down the next radicand pair, trial subtract 4q+1
    assign sh_a = {rem_a_p[ROOT_W-1:0], rad_a_p[RAD_W-1 -: 2]};
    assign sh_b = {rem_b_p[ROOT_W-1:0], rad_b_p[RAD_W-1 -: 2]};
    assign tr_a = {root_a_p, 2'b01};
    assign tr_b = {root_b_p, 2'b01};
    assign ge_a = (sh_a >= tr_a);
    assign ge_b = (sh_b >= tr_b);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[i] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        root_a_r[i] <= {root_a_p[ROOT_W-2:0], ge_a};
        root_b_r[i] <= {root_b_p[ROOT_W-2:0], ge_b};
        tag_r[i]    <= tag_p;
      end
    end

    if (i < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ctl.en) begin
          rad_a_r[i] <= rad_a_p << 2;
          rad_b_r[i] <= rad_b_p << 2;
          rem_a_r[i] <= ge_a ? (sh_a - tr_a) : sh_a;
          rem_b_r[i] <= ge_b ? (sh_b - tr_b) : sh_b;
        end
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign root_a    = root_a_r[ROOT_W-1];
  assign root_b    = root_b_r[ROOT_W-1];
  assign tag_out   = tag_r[ROOT_W-1];

endmodule

FILE: sv/ctp_div_pipe.sv
// ----------------------------------------------------------------------------
// ctp_div_pipe: two-lane pipelined fraction divider
// floor(num * 2^Q_W / den), capped at 2^Q_W, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ctp_div_pipe import ctp_pkg::*; #(
  parameter int DEN_W = SQRT_ROOT_W_DEF,
  parameter int Q_W   = DIV_Q_W_DEF,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pipe_ctl_t        ctl,
  input  logic [DEN_W-1:0] num_a,
  input  logic [DEN_W-1:0] num_b,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [Q_W:0]     quo_a,
  output logic [Q_W:0]     quo_b,
  output logic [TAG_W-1:0] tag_out
);

  // entry stage: overflow flags
  logic             pre_vld_r;
  logic [DEN_W-1:0] pre_num_a_r, pre_num_b_r, pre_den_r;
  logic             pre_full_a_r, pre_full_b_r;
  logic [TAG_W-1:0] pre_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (ctl.en) begin
      pre_vld_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      pre_num_a_r  <= num_a;
      pre_num_b_r  <= num_b;
      pre_den_r    <= den;
      pre_full_a_r <= (num_a >= den) || (den == '0);
      pre_full_b_r <= (num_b >= den) || (den == '0);
      pre_tag_r    <= tag_in;
    end
  end

  logic             vld_r    [Q_W];
  logic [DEN_W-1:0] rem_a_r  [Q_W];
  logic [DEN_W-1:0] rem_b_r  [Q_W];
  logic [DEN_W-1:0] den_r    [Q_W];
  logic [Q_W-1:0]   q_a_r    [Q_W];
  logic [Q_W-1:0]   q_b_r    [Q_W];
  logic             full_a_r [Q_W];
  logic             full_b_r [Q_W];
  logic [TAG_W-1:0] tag_r    [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic             vld_p, full_a_p, full_b_p;
    logic [DEN_W-1:0] rem_a_p, rem_b_p, den_p;
    logic [Q_W-1:0]   q_a_p, q_b_p;
    logic [TAG_W-1:0] tag_p;
    logic [DEN_W:0]   sh_a, sh_b, dd, df_a, df_b;
    logic             ge_a, ge_b;

    if (i == 0) begin : g_first
      assign vld_p    = pre_vld_r;
      assign rem_a_p  = pre_num_a_r;
      assign rem_b_p  = pre_num_b_r;
      assign den_p    = pre_den_r;
      assign q_a_p    = '0;
      assign q_b_p    = '0;
      assign full_a_p = pre_full_a_r;
      assign full_b_p = pre_full_b_r;
      assign tag_p    = pre_tag_r;
    end else begin : g_next
      assign vld_p    = vld_r[i-1];
      assign rem_a_p  = rem_a_r[i-1];
      assign rem_b_p  = rem_b_r[i-1];
      assign den_p    = den_r[i-1];
      assign q_a_p    = q_a_r[i-1];
      assign q_b_p    = q_b_r[i-1];
      assign full_a_p = full_a_r[i-1];
      assign full_b_p = full_b_r[i-1];
      assign tag_p    = tag_r[i-1];
    end

    assign sh_a = {rem_a_p, 1'b0};
    assign sh_b = {rem_b_p, 1'b0};
    assign dd   = {1'b0, den_p};
    assign ge_a = (sh_a >= dd);
    assign ge_b = (sh_b >= dd);
    assign df_a = sh_a - dd;
    assign df_b = sh_b - dd;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[i] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        q_a_r[i]    <= {q_a_p[Q_W-2:0], ge_a};
        q_b_r[i]    <= {q_b_p[Q_W-2:0], ge_b};
        full_a_r[i] <= full_a_p;
        full_b_r[i] <= full_b_p;
        tag_r[i]    <= tag_p;
      end
    end

    if (i < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ctl.en) begin
          rem_a_r[i] <= ge_a ? df_a[DEN_W-1:0] : sh_a[DEN_W-1:0];
          rem_b_r[i] <= ge_b ? df_b[DEN_W-1:0] : sh_b[DEN_W-1:0];
          den_r[i]   <= den_p;
        end
      end
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign quo_a     = full_a_r[Q_W-1] ? {1'b1, {Q_W{1'b0}}} : {1'b0, q_a_r[Q_W-1]};
  assign quo_b     = full_b_r[Q_W-1] ? {1'b1, {Q_W{1'b0}}} : {1'b0, q_b_r[Q_W-1]};
  assign tag_out   = tag_r[Q_W-1];

endmodule

FILE: sv/circle_tangent_point.sv
// ----------------------------------------------------------------------------
// circle_tangent_point: tangent point on a circle seen from an outside point
// G = A + c*(c*D + g*s*(-Dy, Dx)), c = r/d, s = sqrt(d^2 - r^2)/d, in fixed point.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ------------------------------------
//  cfg      in         cfg_we               cfg_wdata (zero_tolerance)
//  in       in         in_valid / in_stall  center, radius, point, tangent sense
//  out      out        out_valid/out_stall  tangent_x, tangent_y, status
//
//  Throughput is one transaction per cycle while in_stall is low. The pipe has
//  three setup stages, the 63-stage square root pipe, a 1 + K stage divider
//  (K = min(62 - COORD_WIDTH, 30)), the ratio snap, three product stages and
//  the output register.
//  Reset (rst_n low, synchronous) empties every stage and sets zero_tolerance to 1.
//  A stalled result parks in a one-entry skid register; in_stall is that register's
//  valid bit, so the whole pipe holds only while both output slots are full.
// ----------------------------------------------------------------------------
module circle_tangent_point import ctp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [TOL_W-1:0]              cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic [COORD_WIDTH-2:0]        in_circle_radius,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic                          in_tangent_sense,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_tangent_x,
  output logic signed [COORD_WIDTH-1:0] out_tangent_y,
  output logic [1:0]                    out_status
);

  localparam int W     = COORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int E     = 62 - W;                 // extra root precision bits
  localparam int K     = (E < 30) ? E : 30;      // fraction bits of c and s
  localparam int DW    = W + 1;                  // difference width
  localparam int D2W   = 2 * DW;                 // squared distance width
  localparam int RADW  = D2W + 2 * E;            // radicand width
  localparam int ROOTW = RADW / 2;
  localparam int PW    = K + 2 + DW;             // c*dx product
  localparam int SW    = PW + 1;                 // rotation sum
  localparam int UW    = SW - K;                 // u, v
  localparam int MW    = K + 2 + UW;             // c*u product
  localparam int RW    = MW - K;
  localparam int XW    = RW + 1;
  localparam int SH1   = (K >= F) ? (K - F) : 0;
  localparam int SH2   = (K >= F) ? 0 : (F - K);
  localparam int CW    = K + F + TOL_W + 1;

  localparam logic signed [SW-1:0] HALF_S = SW'(1) << (K - 1);
  localparam logic signed [MW-1:0] HALF_M = MW'(1) << (K - 1);
  localparam logic [K:0]           ONE_K  = {1'b1, {K{1'b0}}};
  localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

  typedef struct packed {
    status_t                status;
    logic signed [W-1:0]    ax;
    logic signed [W-1:0]    ay;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic                   g;
    logic [W-2:0]           r;
  } sq_side_t;

  typedef struct packed {
    status_t                status;
    logic signed [W-1:0]    ax;
    logic signed [W-1:0]    ay;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic                   g;
  } dv_side_t;

  localparam int SQ_TAG_W = $bits(sq_side_t);
  localparam int DV_TAG_W = $bits(dv_side_t);

  logic en;
  logic skid_valid_r;

  // Advance everything while the skid slot is free
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: differences D = P - A
  // --------------------------------------------------------------------------
  logic                 vA_r;
  logic signed [W-1:0]  axA_r, ayA_r;
  logic signed [DW-1:0] dxA_r, dyA_r;
  logic [W-2:0]         rA_r;
  logic                 gA_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vA_r <= 1'b0;
    end else if (en) begin
      vA_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axA_r <= in_center_x;
      ayA_r <= in_center_y;
      dxA_r <= {in_point_x[W-1], in_point_x} - {in_center_x[W-1], in_center_x};
      dyA_r <= {in_point_y[W-1], in_point_y} - {in_center_y[W-1], in_center_y};
      rA_r  <= in_circle_radius;
      gA_r  <= in_tangent_sense;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: squares d^2, r^2 and tolerance^2
  // --------------------------------------------------------------------------
  logic signed [D2W-1:0] sqx, sqy;
  logic [D2W-1:0]        d2_nxt;
  logic [2*W-3:0]        r2_nxt;
  logic [2*TOL_W-1:0]    tol2_nxt;

  assign sqx      = dxA_r * dxA_r;
  assign sqy      = dyA_r * dyA_r;
  assign d2_nxt   = sqx + sqy;
  assign r2_nxt   = rA_r * rA_r;
  assign tol2_nxt = (2*TOL_W)'(tol_r) * (2*TOL_W)'(tol_r);

  logic                 vB_r;
  logic [D2W-1:0]       d2B_r;
  logic [2*W-3:0]       r2B_r;
  logic [2*TOL_W-1:0]   tol2B_r;
  logic signed [W-1:0]  axB_r, ayB_r;
  logic signed [DW-1:0] dxB_r, dyB_r;
  logic [W-2:0]         rB_r;
  logic                 gB_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vB_r <= 1'b0;
    end else if (en) begin
      vB_r <= vA_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2B_r   <= d2_nxt;
      r2B_r   <= r2_nxt;
      tol2B_r <= tol2_nxt;
      axB_r   <= axA_r;
      ayB_r   <= ayA_r;
      dxB_r   <= dxA_r;
      dyB_r   <= dyA_r;
      rB_r    <= rA_r;
      gB_r    <= gA_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: classify, form both radicands
  // --------------------------------------------------------------------------
  status_t        status_nxt;
  logic [D2W-1:0] diff_nxt;

  always_comb begin
    // radius check wins over the distance checks
    if (rB_r == '0) begin
      status_nxt = ST_BAD_RADIUS;
    end else if (d2B_r <= D2W'(tol2B_r)) begin
      status_nxt = ST_COINCIDENT;
    end else if (d2B_r <= D2W'(r2B_r)) begin
      status_nxt = ST_INSIDE;
    end else begin
      status_nxt = ST_OK;
    end
  end

  assign diff_nxt = d2B_r - D2W'(r2B_r);

  logic            vC_r;
  logic [RADW-1:0] radAC_r, radBC_r;
  sq_side_t        sideC_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vC_r <= 1'b0;
    end else if (en) begin
      vC_r <= vB_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radAC_r        <= {d2B_r, {(2*E){1'b0}}};
      radBC_r        <= {diff_nxt, {(2*E){1'b0}}};
      sideC_r.status <= status_nxt;
      sideC_r.ax     <= axB_r;
      sideC_r.ay     <= ayB_r;
      sideC_r.dx     <= dxB_r;
      sideC_r.dy     <= dyB_r;
      sideC_r.g      <= gB_r;
      sideC_r.r      <= rB_r;
    end
  end

  // --------------------------------------------------------------------------
  // Square roots: d * 2^E and sqrt(d^2 - r^2) * 2^E
  // --------------------------------------------------------------------------
  logic              sq_valid;
  logic [ROOTW-1:0]  dext, sext_root;
  logic [SQ_TAG_W-1:0] sq_tag;
  sq_side_t          sq_side;

  ctp_sqrt_pipe #(
    .RAD_W (RADW),
    .TAG_W (SQ_TAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       ('{en: en, valid: vC_r}),
    .rad_a     (radAC_r),
    .rad_b     (radBC_r),
    .tag_in    (SQ_TAG_W'(sideC_r)),
    .out_valid (sq_valid),
    .root_a    (dext),
    .root_b    (sext_root),
    .tag_out   (sq_tag)
  );

  assign sq_side = sq_side_t'(sq_tag);

  // --------------------------------------------------------------------------
  // Divides: c = r/d and s = sqrt(d^2 - r^2)/d, K fraction bits
  // --------------------------------------------------------------------------
  dv_side_t         dv_in_side;
  logic             dv_valid;
  logic [K:0]       c_q, s_q;
  logic [DV_TAG_W-1:0] dv_tag;
  dv_side_t         dv_side;

  always_comb begin
    dv_in_side.status = sq_side.status;
    dv_in_side.ax     = sq_side.ax;
    dv_in_side.ay     = sq_side.ay;
    dv_in_side.dx     = sq_side.dx;
    dv_in_side.dy     = sq_side.dy;
    dv_in_side.g      = sq_side.g;
  end

  ctp_div_pipe #(
    .DEN_W (ROOTW),
    .Q_W   (K),
    .TAG_W (DV_TAG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       ('{en: en, valid: sq_valid}),
    .num_a     (ROOTW'({sq_side.r, {E{1'b0}}})),
    .num_b     (sext_root),
    .den       (dext),
    .tag_in    (DV_TAG_W'(dv_in_side)),
    .out_valid (dv_valid),
    .quo_a     (c_q),
    .quo_b     (s_q),
    .tag_out   (dv_tag)
  );

  assign dv_side = dv_side_t'(dv_tag);

  // --------------------------------------------------------------------------
  // Stage S: snap a ratio near one to zero angle
  // --------------------------------------------------------------------------
  logic [K:0]    gap;
  logic [CW-1:0] gap_ext, tol_ext;
  logic          snap;

  assign gap     = ONE_K - c_q;
  assign gap_ext = CW'(gap) << SH2;
  assign tol_ext = CW'(tol_r) << SH1;
  assign snap    = (gap_ext <= tol_ext);

  logic     vS_r;
  logic [K:0] cS_r, sS_r;
  dv_side_t sideS_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vS_r <= 1'b0;
    end else if (en) begin
      vS_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cS_r    <= snap ? ONE_K : c_q;
      sS_r    <= snap ? '0 : s_q;
      sideS_r <= dv_side;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P1: the four rotation products
  // --------------------------------------------------------------------------
  logic signed [K+1:0]  cS_sg, sS_sg;
  logic signed [DW-1:0] dxS, dyS;

  assign cS_sg = signed'({1'b0, cS_r});
  assign sS_sg = signed'({1'b0, sS_r});
  assign dxS   = sideS_r.dx;
  assign dyS   = sideS_r.dy;

  logic                vP1_r;
  logic signed [PW-1:0] cdxP1_r, cdyP1_r, sdxP1_r, sdyP1_r;
  logic [K:0]           cP1_r;
  logic signed [W-1:0]  axP1_r, ayP1_r;
  logic                 gP1_r;
  status_t              stP1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vP1_r <= 1'b0;
    end else if (en) begin
      vP1_r <= vS_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cdxP1_r <= cS_sg * dxS;
      cdyP1_r <= cS_sg * dyS;
      sdxP1_r <= sS_sg * dxS;
      sdyP1_r <= sS_sg * dyS;
      cP1_r   <= cS_r;
      axP1_r  <= sideS_r.ax;
      ayP1_r  <= sideS_r.ay;
      gP1_r   <= sideS_r.g;
      stP1_r  <= sideS_r.status;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P2: u = rnd((c*dx - g*s*dy) / 2^K), v = rnd((c*dy + g*s*dx) / 2^K)
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] cdx_e, cdy_e, sdx_e, sdy_e, su, sv, su_r, sv_r;

  assign cdx_e = {cdxP1_r[PW-1], cdxP1_r};
  assign cdy_e = {cdyP1_r[PW-1], cdyP1_r};
  assign sdx_e = {sdxP1_r[PW-1], sdxP1_r};
  assign sdy_e = {sdyP1_r[PW-1], sdyP1_r};
  // clockwise side flips the sign of the s terms
  assign su    = gP1_r ? (cdx_e + sdy_e) : (cdx_e - sdy_e);
  assign sv    = gP1_r ? (cdy_e - sdx_e) : (cdy_e + sdx_e);
  assign su_r  = su + HALF_S;
  assign sv_r  = sv + HALF_S;

  logic                 vP2_r;
  logic signed [UW-1:0] uP2_r, vvP2_r;
  logic [K:0]           cP2_r;
  logic signed [W-1:0]  axP2_r, ayP2_r;
  status_t              stP2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vP2_r <= 1'b0;
    end else if (en) begin
      vP2_r <= vP1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uP2_r  <= su_r[SW-1:K];
      vvP2_r <= sv_r[SW-1:K];
      cP2_r  <= cP1_r;
      axP2_r <= axP1_r;
      ayP2_r <= ayP1_r;
      stP2_r <= stP1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P3: scale by c once more
  // --------------------------------------------------------------------------
  logic signed [K+1:0] cP2_sg;

  assign cP2_sg = signed'({1'b0, cP2_r});

  logic                 vP3_r;
  logic signed [MW-1:0] cuP3_r, cvP3_r;
  logic signed [W-1:0]  axP3_r, ayP3_r;
  status_t              stP3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vP3_r <= 1'b0;
    end else if (en) begin
      vP3_r <= vP2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cuP3_r <= cP2_sg * uP2_r;
      cvP3_r <= cP2_sg * vvP2_r;
      axP3_r <= axP2_r;
      ayP3_r <= ayP2_r;
      stP3_r <= stP2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Final: round, offset by the center, saturate, zero on any error
  // --------------------------------------------------------------------------
  logic signed [MW-1:0] cu_r, cv_r;
  logic signed [RW-1:0] rx, ry;
  logic signed [XW-1:0] sum_x, sum_y;
  logic signed [W-1:0]  fin_x, fin_y;

  assign cu_r  = cuP3_r + HALF_M;
  assign cv_r  = cvP3_r + HALF_M;
  assign rx    = cu_r[MW-1:K];
  assign ry    = cv_r[MW-1:K];
  assign sum_x = {{(XW-W){axP3_r[W-1]}}, axP3_r} + {rx[RW-1], rx};
  assign sum_y = {{(XW-W){ayP3_r[W-1]}}, ayP3_r} + {ry[RW-1], ry};

  always_comb begin
    if (stP3_r != ST_OK) begin
      fin_x = '0;
      fin_y = '0;
    end else begin
      if (sum_x > SAT_HI) begin
        fin_x = SAT_HI[W-1:0];
      end else if (sum_x < SAT_LO) begin
        fin_x = SAT_LO[W-1:0];
      end else begin
        fin_x = sum_x[W-1:0];
      end
      if (sum_y > SAT_HI) begin
        fin_y = SAT_HI[W-1:0];
      end else if (sum_y < SAT_LO) begin
        fin_y = SAT_LO[W-1:0];
      end else begin
        fin_y = sum_y[W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register with one-entry skid
  // --------------------------------------------------------------------------
  logic                out_valid_r, out_valid_nxt, skid_valid_nxt;
  logic                out_load, out_from_skid, skid_load;
  logic signed [W-1:0] out_x_r, out_y_r, skid_x_r, skid_y_r;
  status_t             out_st_r, skid_st_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_load       = 1'b0;
    out_from_skid  = 1'b0;
    skid_load      = 1'b0;
    if (out_valid_r && !out_stall) begin
      if (skid_valid_r) begin
        // drain the parked transaction first
        out_from_skid  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = vP3_r;
        out_load      = vP3_r;
      end
    end else if (!out_valid_r) begin
      out_valid_nxt = vP3_r;
      out_load      = vP3_r;
    end else if (vP3_r && !skid_valid_r) begin
      // output held: park the arriving transaction
      skid_valid_nxt = 1'b1;
      skid_load      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_from_skid) begin
      out_x_r  <= skid_x_r;
      out_y_r  <= skid_y_r;
      out_st_r <= skid_st_r;
    end else if (out_load) begin
      out_x_r  <= fin_x;
      out_y_r  <= fin_y;
      out_st_r <= stP3_r;
    end
    if (skid_load) begin
      skid_x_r  <= fin_x;
      skid_y_r  <= fin_y;
      skid_st_r <= stP3_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tangent_x = out_x_r;
  assign out_tangent_y = out_y_r;
  assign out_status    = out_st_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a transaction while the output register is empty");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && skid_valid_r) |=> (out_valid_r && !skid_valid_r))
    else $error("skid transaction not moved to the output register");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r != ST_OK)) |-> ((out_x_r == '0) && (out_y_r == '0)))
    else $error("error status with a nonzero tangent point");

  a_bad_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (vB_r && en && (rB_r == '0)) |=> (vC_r && (sideC_r.status == ST_BAD_RADIUS)))
    else $error("zero radius not flagged as bad radius");

endmodule

FILE: test/tb_circle_tangent_point.sv
// ----------------------------------------------------------------------------
// tb_circle_tangent_point: self-checking bench for the tangent point block
// Drives directed and random circle/point queries through the valid/stall
// handshake, predicts each tangent point in fixed point and checks every result.
// ----------------------------------------------------------------------------
module tb_circle_tangent_point import ctp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W      = 32;
  localparam int FRAC   = 16;
  localparam int EXTB   = 62 - W;                   // extra root precision bits
  localparam int KB     = (62 - W) < 30 ? (62 - W) : 30;  // ratio fraction bits
  localparam int LATENCY = 72 + KB;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic signed [W-1:0] cx, cy;
    logic [W-2:0]        rad;
    logic signed [W-1:0] px, py;
    logic                sense;
  } query_t;

  typedef struct {
    logic signed [W-1:0] tx, ty;
    status_t             st;
  } tangent_t;

  // Scoreboard: predicts the tangent point of each accepted query and holds
  // the expectations in arrival order.
  class tangent_scoreboard;
    tangent_t   expected_q[$];
    logic [15:0] tol;
    int         errors;

    function new();
      tol    = TOL_RESET;
      errors = 0;
    endfunction

    function logic [63:0] isqrt(logic [127:0] n);
      logic [63:0] res, cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = res | (64'd1 << b);
        if (({64'd0, cand} * {64'd0, cand}) <= n) res = cand;
      end
      return res;
    endfunction

    // floor(num * 2^bits / den), capped at 2^bits; shifts wrap at 64 bits
    function logic [63:0] ratio(logic [63:0] num, logic [63:0] den, int bits);
      logic [63:0] q;
      q = '0;
      if (den == 0 || num >= den) return 64'd1 << bits;
      for (int i = 0; i < bits; i++) begin
        num = num << 1;
        q   = q << 1;
        if (num >= den) begin
          num = num - den;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function longint round_shift(longint v);
      v = v + (64'sd1 <<< (KB - 1));
      return v >>> KB;
    endfunction

    function logic signed [W-1:0] clamp(longint v);
      longint lim;
      lim = (64'sd1 <<< (W - 1)) - 1;
      if (v > lim) v = lim;
      if (v < -lim - 1) v = -lim - 1;
      return v[W-1:0];
    endfunction

    function tangent_t tangent_of(query_t q);
      tangent_t    t;
      longint      ax, ay, dx, dy, g, cl, sl, u, v;
      logic [63:0] r, adx, ady, dext, sroot, cq, sq, gap;
      logic [127:0] d2, r2, tmp;
      ax = q.cx; ay = q.cy;
      dx = longint'(q.px) - ax;
      dy = longint'(q.py) - ay;
      r  = {33'd0, q.rad};
      g  = q.sense ? -1 : 1;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      d2 = {64'd0, adx} * {64'd0, adx} + {64'd0, ady} * {64'd0, ady};
      r2 = {64'd0, r} * {64'd0, r};
      t.tx = '0; t.ty = '0; t.st = ST_OK;
      if (r == 0) begin
        t.st = ST_BAD_RADIUS; return t;
      end
      if (d2 <= {112'd0, tol} * {112'd0, tol}) begin
        t.st = ST_COINCIDENT; return t;
      end
      if (d2 <= r2) begin
        t.st = ST_INSIDE; return t;
      end
      tmp   = d2 << (2 * EXTB);
      dext  = isqrt(tmp);
      tmp   = (d2 - r2) << (2 * EXTB);
      sroot = isqrt(tmp);
      cq = ratio(r << EXTB, dext, KB);
      sq = ratio(sroot, dext, KB);
      // snap the tangent point to the query point when r/d is within tolerance of one
      gap = (64'd1 << KB) - cq;
      if (gap <= ({48'd0, tol} << (KB - FRAC))) begin
        cq = 64'd1 << KB;
        sq = 0;
      end
      cl = cq; sl = sq;
      u = round_shift(cl * dx - g * (sl * dy));
      v = round_shift(cl * dy + g * (sl * dx));
      t.tx = clamp(ax + round_shift(cl * u));
      t.ty = clamp(ay + round_shift(cl * v));
      return t;
    endfunction

    function void note_input(query_t q);
      expected_q.push_back(tangent_of(q));
    endfunction

    function void check_result(logic signed [W-1:0] tx, logic signed [W-1:0] ty,
                               logic [1:0] st);
      tangent_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d status=%0d", $realtime, tx, ty, st);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $realtime, e.st, st);
        errors++;
      end
      if (tx !== e.tx) begin
        $display("%0t: tangent_x expected %0d actual %0d", $realtime, e.tx, tx);
        errors++;
      end
      if (ty !== e.ty) begin
        $display("%0t: tangent_y expected %0d actual %0d", $realtime, e.ty, ty);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [W-1:0] in_center_x = '0, in_center_y = '0;
  logic [W-2:0] in_circle_radius = '0;
  logic signed [W-1:0] in_point_x = '0, in_point_y = '0;
  logic in_tangent_sense = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [W-1:0] out_tangent_x, out_tangent_y;
  logic [1:0] out_status;

  tangent_scoreboard sb = new();

  // burst shaping of the sender and hold-off request to the receiver
  int burst_left = 0;
  bit hold_req = 1'b0;

  circle_tangent_point #(.COORD_WIDTH(W), .FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_center_x(in_center_x), .in_center_y(in_center_y),
    .in_circle_radius(in_circle_radius),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_tangent_sense(in_tangent_sense),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tangent_x(out_tangent_x), .out_tangent_y(out_tangent_y),
    .out_status(out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one transaction and hold it until accepted. Call at a rising edge.
  // Drop valid for a random gap only at the end of a burst, so valid is never
  // lowered and raised in the same step.
  task automatic send(query_t q);
    int gap;
    if (burst_left == 0) burst_left = $urandom_range(1, 40);
    in_valid         <= 1'b1;
    in_center_x      <= q.cx;
    in_center_y      <= q.cy;
    in_circle_radius <= q.rad;
    in_point_x       <= q.px;
    in_point_y       <= q.py;
    in_tangent_sense <= q.sense;
    do @(posedge clk); while (in_stall);
    sb.note_input(q);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_fields(logic signed [W-1:0] cx, logic signed [W-1:0] cy,
                             logic [W-2:0] rad, logic signed [W-1:0] px,
                             logic signed [W-1:0] py, logic sense);
    query_t q;
    q.cx = cx; q.cy = cy; q.rad = rad; q.px = px; q.py = py; q.sense = sense;
    send(q);
  endtask

  // Drain the pipe, then write the tolerance while the block is idle.
  task automatic write_tolerance(logic [15:0] value);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.tol = value;
  endtask

  function automatic query_t random_query();
    query_t q;
    int mode;
    logic signed [W-1:0] off;
    mode = $urandom_range(0, 9);
    q.sense = 1'($urandom_range(0, 1));
    q.cx = $urandom; q.cy = $urandom;
    q.px = $urandom; q.py = $urandom;
    q.rad = 31'($urandom);
    case (mode)
      0, 1, 2, 3, 4: begin
        // ordinary geometry at moderate scale
        q.cx  = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        q.cy  = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        q.rad = 31'($urandom_range(1, 32'h0040_0000));
        q.px  = q.cx + $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        q.py  = q.cy + $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      end
      5: begin
        // point just outside the circle: ratio close to one
        q.rad = 31'($urandom_range(32'h100, 32'h0100_0000));
        off   = $urandom_range(0, 32'h1000);
        q.px  = q.cx + $signed({1'b0, q.rad}) + off;
        q.py  = q.cy + $signed($urandom_range(0, 32'h20)) - 32'sd16;
      end
      6, 7: ;  // every field fully random
      8: begin
        case ($urandom_range(0, 2))
          0: q.rad = '0;
          1: begin
            q.px = q.cx + $signed($urandom_range(0, 4)) - 32'sd2;
            q.py = q.cy;
          end
          default: begin
            q.rad = 31'($urandom_range(32'h1_0000, 32'h4000_0000));
            q.px  = q.cx + $signed($urandom_range(0, 32'hFFFF));
            q.py  = q.cy;
          end
        endcase
      end
      default: begin
        // huge circle near the edge of the range: saturating results
        q.rad = 31'(32'h7FFF_FFFF - $urandom_range(0, 32'hFFFF));
        q.cx  = $urandom_range(0, 1) ? 32'sh7FFF_0000 : -32'sh7FFF_0000;
        q.cy  = $signed($urandom);
      end
    endcase
    return q;
  endfunction

  // Receiver: check each accepted result, then pick the next stall level.
  int stall_pct = 0;
  int mode_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_tangent_x, out_tangent_y, out_status);
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      // long hold-off so the pipe fills and pushes back on the sender
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    logic [15:0] tol_plan[4];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cases at the reset tolerance
    send_fields(32'sd0, 32'sd0, '0, 32'sd65536, 32'sd0, 1'b0);            // bad radius
    send_fields(32'sd5, 32'sd5, '0, 32'sd5, 32'sd5, 1'b1);                // bad radius, same point
    send_fields(32'sd100, 32'sd100, 31'd65536, 32'sd100, 32'sd100, 1'b0); // coincident
    send_fields(32'sd0, 32'sd0, 31'd65536, 32'sd1, 32'sd0, 1'b0);         // coincident at tol
    send_fields(32'sd0, 32'sd0, 31'd655360, 32'sd65536, 32'sd0, 1'b1);    // inside
    send_fields(32'sd0, 32'sd0, 31'd655360, 32'sd655360, 32'sd0, 1'b0);   // on the circle
    send_fields(32'sd0, 32'sd0, 31'd65536, 32'sd131072, 32'sd0, 1'b0);    // ccw
    send_fields(32'sd0, 32'sd0, 31'd65536, 32'sd131072, 32'sd0, 1'b1);    // cw
    send_fields(-32'sd65536, 32'sd65536, 31'd65536, 32'sd0, -32'sd131072, 1'b0);
    send_fields(32'sd0, 32'sd0, 31'd6553600, 32'sd6553601, 32'sd0, 1'b0); // ratio snap
    send_fields(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
                -32'sh8000_0000, -32'sh8000_0000, 1'b0);
    send_fields(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
                -32'sh8000_0000, -32'sh8000_0000, 1'b1);
    send_fields(-32'sh8000_0000, -32'sh8000_0000, 31'h7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_fields(32'sh7000_0000, 32'sd0, 31'h4000_0000,
                -32'sh2000_0000, 32'sd0, 1'b0);                            // large coordinates, no saturation
    send_fields(-32'sh8000_0000, 32'sh7FFF_FFFF, 31'd1,
                32'sh7FFF_FFFF, -32'sh8000_0000, 1'b0);
    send_fields(32'sd0, 32'sd0, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);

    tol_plan[0] = 16'd1;
    tol_plan[1] = 16'd0;
    tol_plan[2] = 16'hFFFF;
    tol_plan[3] = 16'($urandom_range(2, 16'hFFFE));
    for (int ph = 0; ph < 4; ph++) begin
      write_tolerance(tol_plan[ph]);
      if (tol_plan[ph] == 16'hFFFF) begin
        // widest tolerance: coincidence boundary
        send_fields(32'sd0, 32'sd0, 31'd1, 32'sd65535, 32'sd0, 1'b0);
        send_fields(32'sd0, 32'sd0, 31'd1, 32'sd65536, 32'sd0, 1'b1);
      end
      for (int i = 0; i < 310; i++) begin
        if (i == 100) hold_req = 1'b1;
        send(random_query());
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0 && !out_valid) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: circle_tangent_point.f
sv/ctp_pkg.sv
sv/ctp_sqrt_pipe.sv
sv/ctp_div_pipe.sv
sv/circle_tangent_point.sv
test/tb_circle_tangent_point.sv
